// File: sv/typed_value_to_float32_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TYPED_VALUE_TO_FLOAT32_TOP_DEFINES_SVH
`define TYPED_VALUE_TO_FLOAT32_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TVF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TVF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/tvf_pkg.sv
// Types and constants for the typed value to float32 converter.
`default_nettype none
package tvf_pkg;
    typedef enum logic [2:0] {
        CMD_U8  = 3'd0,
        CMD_S8  = 3'd1,
        CMD_U16 = 3'd2,
        CMD_S16 = 3'd3,
        CMD_U32 = 3'd4,
        CMD_S32 = 3'd5,
        CMD_F32 = 3'd6,
        CMD_F16 = 3'd7
    } cmd_t;

    localparam logic [31:0] F32_EXP_ALL_ONES = 32'h7f80_0000;
    localparam logic [7:0]  EXP_BIAS_DIFF    = 8'd112; // 127 - 15
    localparam logic [7:0]  F32_BIAS         = 8'd127;

    // Number of raw bytes each type code needs.
    function automatic logic [2:0] type_size(input cmd_t c);
        logic [2:0] s;
        unique case (c)
            CMD_U8, CMD_S8:            s = 3'd1;
            CMD_U16, CMD_S16, CMD_F16: s = 3'd2;
            default:                   s = 3'd4;
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

// File: sv/typed_value_to_float32_top.sv
// Top level: typed raw value to IEEE-754 single-precision converter.
`default_nettype none
// Converts one beat (type code, up to four little-endian bytes, byte count)
// into float32 bits. Accepts a beat every cycle unless the output register
// is stalled; the result appears in the output register in the cycle after
// acceptance, throughput one beat per cycle. A stalled output register holds
// the input side as well. Integers round to nearest even; half precision is
// widened exactly; a byte count that does not match the type gives +0.0.
module typed_value_to_float32_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_cmd,
    input  wire  [31:0] s_raw_value,
    input  wire  [2:0]  s_byte_count,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_float_bits
);
    import tvf_pkg::*;

    cmd_t        cmd;
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  msb;
    logic        found;
    logic [31:0] norm;
    logic        rnd_up;
    logic [24:0] mant_r;
    logic [7:0]  expo;
    logic [31:0] int_bits;
    logic [31:0] half_bits;
    logic [31:0] result;
    logic [3:0]  lz;
    logic [9:0]  hf;
    logic [4:0]  he;
    logic [9:0]  hf_n;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_float_bits_reg;

    assign cmd = cmd_t'(s_cmd);

    // Sign and magnitude of the integer types
    always_comb begin
        neg = 1'b0;
        mag = 32'd0;
        unique case (cmd)
            CMD_U8:  mag = {24'd0, s_raw_value[7:0]};
            CMD_S8: begin
                neg = s_raw_value[7];
                mag = {24'd0, neg ? 8'(-s_raw_value[7:0]) : s_raw_value[7:0]};
                if (neg && s_raw_value[7:0] == 8'h80) mag = 32'd128;
            end
            CMD_U16: mag = {16'd0, s_raw_value[15:0]};
            CMD_S16: begin
                neg = s_raw_value[15];
                mag = neg ? (32'h0001_0000 - {16'd0, s_raw_value[15:0]})
                          : {16'd0, s_raw_value[15:0]};
            end
            CMD_S32: begin
                neg = s_raw_value[31];
                mag = neg ? (32'd0 - s_raw_value) : s_raw_value;
            end
            default: mag = s_raw_value;
        endcase
    end

    // Leading one position
    always_comb begin
        msb = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && mag[i]) begin
                msb = 5'(i);
                found = 1'b1;
            end
        end
    end

    // Normalize, round to nearest even
    always_comb begin
        norm = mag << (5'd31 - msb);
        rnd_up = norm[7] && (norm[8] || (norm[6:0] != 7'd0));
        mant_r = {1'b0, norm[31:8]} + {24'd0, rnd_up};
        expo = F32_BIAS + {3'd0, msb} + {7'd0, mant_r[24]};
        if (!found)
            int_bits = 32'd0;
        else
            int_bits = {neg, expo, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
    end

    // Half precision widening
    always_comb begin
        hf = s_raw_value[9:0];
        he = s_raw_value[14:10];
        lz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (hf[i]) lz = 4'(9 - i);
        end
        hf_n = 10'(hf << (lz + 4'd1));
        if (he == 5'd0) begin
            if (hf == 10'd0)
                half_bits = {s_raw_value[15], 31'd0};
            else
                half_bits = {s_raw_value[15], EXP_BIAS_DIFF - {4'd0, lz}, hf_n, 13'd0};
        end else if (he == 5'h1f) begin
            half_bits = {s_raw_value[15], 31'd0} | F32_EXP_ALL_ONES | {9'd0, hf, 13'd0};
        end else begin
            half_bits = {s_raw_value[15], EXP_BIAS_DIFF + {3'd0, he}, hf, 13'd0};
        end
    end

    // Result select
    always_comb begin
        if (s_byte_count != type_size(cmd))
            result = 32'd0;
        else if (cmd == CMD_F32)
            result = s_raw_value;
        else if (cmd == CMD_F16)
            result = half_bits;
        else
            result = int_bits;
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid_next = (s_valid && s_ready) || (m_valid_reg && !m_ready);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            m_float_bits_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_float_bits = m_float_bits_reg;
endmodule
`default_nettype wire

// File: sv/tvf_checker.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none
`include "typed_value_to_float32_top_defines.svh"
module tvf_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire [2:0]  s_byte_count,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_float_bits
);
    // Beat accepted with a byte count above four yields +0.0
    `TVF_ASSERT_NEXT(a_mismatch_zero, aclk, aresetn, s_valid && s_ready && s_byte_count > 3'd4, m_valid && m_float_bits == 32'd0)
    // Accepted input always produces a result next cycle
    `TVF_ASSERT_NEXT(a_accept_out, aclk, aresetn, s_valid && s_ready, m_valid)
    // Free output side never stalls the input
    `TVF_ASSERT_IMPL(a_ready, aclk, aresetn, !m_valid || m_ready, s_ready)
    // Stalled result holds
    `TVF_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_float_bits))
endmodule

bind typed_value_to_float32_top tvf_checker u_tvf_checker (.*);
`default_nettype wire

// File: tb/typed_value_to_float32_top_tb.sv
// Testbench for the typed value to float32 converter: directed table plus random beats.
`timescale 1ns / 100ps
`default_nettype none
module typed_value_to_float32_top_tb;
    import tvf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = CMD_U8;
    logic [31:0] s_raw_value = '0;
    logic [2:0]  s_byte_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_float_bits;

    typed_value_to_float32_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_raw_value(s_raw_value), .s_byte_count(s_byte_count),
        .m_valid(m_valid), .m_ready(m_ready), .m_float_bits(m_float_bits)
    );

    always #2 aclk = ~aclk;

    // Expected float bits, oldest first
    logic [31:0] float_q[$];
    int          err_cnt = 0;
    int          beats_out = 0;
    int          beats_in = 0;
    bit          rx_quiet = 1'b0;   // no random stalls on the receiver
    bit          rx_hold = 1'b0;    // long receiver hold-off
    int          idle_pct = 13;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h (beat %0d)", what, got, want, beats_out);
        err_cnt++;
    endtask

    // Integer magnitude to float32, round to nearest even
    function automatic logic [31:0] int_to_float(input logic [31:0] mag, input bit neg);
        int          msb;
        int          sh;
        logic [7:0]  ex;
        logic [32:0] mant;
        logic [31:0] rem;
        logic [31:0] half;
        if (mag == 0) return 32'h0;
        msb = 31;
        while (!mag[msb]) msb--;
        ex = 8'(int'(F32_BIAS) + msb);
        if (msb <= 23) begin
            mant = 33'(mag) << (23 - msb);
        end else begin
            sh = msb - 23;
            mant = 33'(mag >> sh);
            rem = mag & ((32'h1 << sh) - 1);
            half = 32'h1 << (sh - 1);
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant[24]) begin
                mant = mant >> 1;
                ex++;
            end
        end
        return {neg, ex, mant[22:0]};
    endfunction

    // Half precision widened to single precision
    function automatic logic [31:0] half_to_float(input logic [15:0] h);
        logic [4:0]  he;
        logic [10:0] fr;
        int          n;
        he = h[14:10];
        fr = {1'b0, h[9:0]};
        n = 0;
        if (he == 0) begin
            if (fr == 0) return {h[15], 31'h0};
            while (!fr[10]) begin
                fr = fr << 1;
                n++;
            end
            return {h[15], 8'(int'(EXP_BIAS_DIFF) + 1 - n), fr[9:0], 13'h0};
        end
        if (he == 5'h1f) return {h[15], 31'h0} | F32_EXP_ALL_ONES | {9'h0, h[9:0], 13'h0};
        return {h[15], 8'(he) + EXP_BIAS_DIFF, h[9:0], 13'h0};
    endfunction

    function automatic logic [31:0] convert_value(input cmd_t c, input logic [31:0] raw,
                                                  input logic [2:0] cnt);
        logic [2:0] need;
        unique case (c)
            CMD_U8, CMD_S8:            need = 3'd1;
            CMD_U16, CMD_S16, CMD_F16: need = 3'd2;
            default:                   need = 3'd4;
        endcase
        if (cnt != need) return 32'h0;
        case (c)
            CMD_U8:  return int_to_float({24'h0, raw[7:0]}, 1'b0);
            CMD_S8:  return raw[7] ? int_to_float(32'h100 - raw[7:0], 1'b1)
                                   : int_to_float({24'h0, raw[7:0]}, 1'b0);
            CMD_U16: return int_to_float({16'h0, raw[15:0]}, 1'b0);
            CMD_S16: return raw[15] ? int_to_float(32'h10000 - raw[15:0], 1'b1)
                                    : int_to_float({16'h0, raw[15:0]}, 1'b0);
            CMD_U32: return int_to_float(raw, 1'b0);
            CMD_S32: return raw[31] ? int_to_float(-raw, 1'b1) : int_to_float(raw, 1'b0);
            CMD_F32: return raw;
            default: return half_to_float(raw[15:0]);
        endcase
    endfunction

    // Drive one beat and wait for its acceptance; the expectation is the typed-in value
    // or the predictor. Idle cycles, if any, come before the beat.
    task automatic send_beat(input cmd_t c, input logic [31:0] raw, input logic [2:0] cnt,
                             input bit typed, input logic [31:0] want, input bit gaps);
        logic [31:0] pred;
        while (gaps && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        pred = convert_value(c, raw, cnt);
        if (typed && pred != want) report_mismatch("table vs predictor", pred, want);
        s_valid <= 1'b1;
        s_cmd <= c;
        s_raw_value <= raw;
        s_byte_count <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        float_q = {float_q, (typed ? want : pred)};
        beats_in++;
    endtask

    // Receiver: random stalls, or a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_hold && (rx_quiet || $urandom_range(99) >= idle_pct);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (float_q.size() == 0) begin
                report_mismatch("unexpected beat", m_float_bits, 32'h0);
            end else begin
                if (m_float_bits !== float_q[0])
                    report_mismatch("float_bits", m_float_bits, float_q[0]);
                void'(float_q.pop_front());
            end
        end
    end

    // Directed table: cmd, raw, count, typed-in flag, expected
    typedef struct {
        cmd_t        c;
        logic [31:0] raw;
        logic [2:0]  cnt;
        bit          typed;
        logic [31:0] want;
    } vec_t;

    vec_t dir_tbl[] = '{
        '{CMD_U8,  32'hffff_ff00, 3'd1, 1'b1, 32'h0000_0000},
        '{CMD_U8,  32'h0000_00ff, 3'd1, 1'b1, 32'h437f_0000},
        '{CMD_S8,  32'h0000_0080, 3'd1, 1'b1, 32'hc300_0000},
        '{CMD_S8,  32'h0000_007f, 3'd1, 1'b0, 32'h0},
        '{CMD_U16, 32'h0000_ffff, 3'd2, 1'b0, 32'h0},
        '{CMD_S16, 32'h0000_8000, 3'd2, 1'b1, 32'hc700_0000},
        '{CMD_S16, 32'h1234_ffff, 3'd2, 1'b1, 32'hbf80_0000},
        '{CMD_U32, 32'hffff_ffff, 3'd4, 1'b1, 32'h4f80_0000},
        '{CMD_U32, 32'h0100_0001, 3'd4, 1'b0, 32'h0},
        '{CMD_U32, 32'h0100_0003, 3'd4, 1'b0, 32'h0},
        '{CMD_S32, 32'h8000_0000, 3'd4, 1'b1, 32'hcf00_0000},
        '{CMD_S32, 32'h7fff_ffff, 3'd4, 1'b1, 32'h4f00_0000},
        '{CMD_S32, 32'h0000_0000, 3'd4, 1'b1, 32'h0000_0000},
        '{CMD_F32, 32'h7fc0_0001, 3'd4, 1'b1, 32'h7fc0_0001},
        '{CMD_F32, 32'hffff_ffff, 3'd4, 1'b1, 32'hffff_ffff},
        '{CMD_F16, 32'h0000_8000, 3'd2, 1'b1, 32'h8000_0000},
        '{CMD_F16, 32'h0000_0001, 3'd2, 1'b1, 32'h3380_0000},
        '{CMD_F16, 32'h0000_03ff, 3'd2, 1'b0, 32'h0},
        '{CMD_F16, 32'h0000_7c00, 3'd2, 1'b1, 32'h7f80_0000},
        '{CMD_F16, 32'h0000_fe01, 3'd2, 1'b1, 32'hffc0_2000},
        '{CMD_F16, 32'h0000_3c00, 3'd2, 1'b1, 32'h3f80_0000},
        '{CMD_U8,  32'h0000_00ff, 3'd0, 1'b1, 32'h0000_0000},
        '{CMD_F32, 32'h3f80_0000, 3'd2, 1'b1, 32'h0000_0000},
        '{CMD_S16, 32'h0000_8000, 3'd7, 1'b1, 32'h0000_0000},
        '{CMD_U16, 32'h0000_0001, 3'd5, 1'b1, 32'h0000_0000}
    };

    // Random beat: mostly matching byte counts, some mismatches, varied magnitudes
    task automatic random_beat(input bit gaps);
        cmd_t        c;
        logic [31:0] raw;
        logic [2:0]  cnt;
        c = cmd_t'($urandom_range(7));
        raw = $urandom();
        if ($urandom_range(3) == 0) raw = raw >> $urandom_range(31);
        case (c)
            CMD_U8, CMD_S8:            cnt = 3'd1;
            CMD_U16, CMD_S16, CMD_F16: cnt = 3'd2;
            default:                   cnt = 3'd4;
        endcase
        if ($urandom_range(9) == 0) cnt = 3'($urandom_range(7));
        send_beat(c, raw, cnt, 1'b0, 32'h0, gaps);
    endtask

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i])
            send_beat(dir_tbl[i].c, dir_tbl[i].raw, dir_tbl[i].cnt,
                      dir_tbl[i].typed, dir_tbl[i].want, 1'b1);

        // Sender pauses until all results are back
        s_valid <= 1'b0;
        while (float_q.size() != 0) @(posedge aclk);

        for (k = 0; k < 500; k++) random_beat(1'b1);

        // Long receiver hold-off while the sender keeps offering beats
        fork
            begin
                rx_hold = 1'b1;
                repeat (60) @(posedge aclk);
                rx_hold = 1'b0;
            end
            for (int j = 0; j < 40; j++) random_beat(1'b0);
        join

        // Stretch with no idling on either side
        rx_quiet = 1'b1;
        for (k = 0; k < 300; k++) random_beat(1'b0);
        rx_quiet = 1'b0;

        for (k = 0; k < 410; k++) random_beat(1'b1);
        s_valid <= 1'b0;

        while (float_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Run covered %0d beats in, %0d results out: all type codes,", beats_in, beats_out);
        $display("size mismatches, rounding ties, half subnormals/inf/NaN and stalls.");
        if (err_cnt == 0 && float_q.size() == 0) begin
            $display("typed_value_to_float32_top verification clean");
        end else begin
            $display("typed_value_to_float32_top verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("typed_value_to_float32_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+sv
sv/tvf_pkg.sv
sv/typed_value_to_float32_top.sv
sv/tvf_checker.sv
tb/typed_value_to_float32_top_tb.sv
